/* rtl/grid_maze_dfs_carver_core_macros.svh */
// Assertion macros shared by the maze carver RTL.
`ifndef GRID_MAZE_DFS_CARVER_CORE_MACROS_SVH
`define GRID_MAZE_DFS_CARVER_CORE_MACROS_SVH

// same-cycle implication
`define GMDC_AST_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GMDC_AST_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/gmdc_pkg.sv */
// Shared types, codes and helpers of the maze carver.
`default_nettype none

package gmdc_pkg;

	localparam int unsigned SZW = 9;
	localparam int unsigned EPW = 4;

	localparam logic [5:0] GRID_RESET = 6'd32;
	localparam logic [3:0] WALLS_ALL  = 4'hF;

	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_STEP  = 2'd1,
		ACT_READ  = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		EV_STARTED     = 3'd0,
		EV_CARVED      = 3'd1,
		EV_BACKTRACKED = 3'd2,
		EV_FINISHED    = 3'd3,
		EV_WALLS       = 3'd4
	} event_t;

	localparam logic [1:0] DIR_XM = 2'd0;
	localparam logic [1:0] DIR_XP = 2'd1;
	localparam logic [1:0] DIR_YP = 2'd2;
	localparam logic [1:0] DIR_YM = 2'd3;

	// neighbor scan order: x-1, x+1, y-1, y+1
	localparam logic [1:0] SLOT_DIR [4] = '{DIR_XM, DIR_XP, DIR_YM, DIR_YP};

	typedef struct packed {
		logic [EPW-1:0] tag;
		logic           visited;
		logic [3:0]     walls;
	} cell_t;

	typedef struct packed {
		logic       any;
		logic [1:0] slot;
		logic [1:0] dir;
	} pick_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [4:0] x;
		logic [4:0] y;
		logic [1:0] dir;
		logic [3:0] walls;
	} result_t;

	// stale generation reads as a fresh cell
	function automatic cell_t cell_view(cell_t c, logic [EPW-1:0] epoch);
		cell_t v;
		v = c;
		if (c.tag != epoch) begin
			v.visited = 1'b0;
			v.walls   = WALLS_ALL;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

/* rtl/gmdc_if.sv */
// Channel interfaces: command in, event out, register write.
`default_nettype none

interface gmdc_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] rand_value;
	logic [4:0] cell_x;
	logic [4:0] cell_y;
	modport source (output valid, action, rand_value, cell_x, cell_y, input ready);
	modport sink (input valid, action, rand_value, cell_x, cell_y, output ready);
endinterface

interface gmdc_evt_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_kind;
	logic [4:0] at_x;
	logic [4:0] at_y;
	logic [1:0] carve_dir;
	logic [3:0] wall_bits;
	logic       maze_done;
	modport source (output valid, event_kind, at_x, at_y, carve_dir, wall_bits, maze_done,
		input ready);
	modport sink (input valid, event_kind, at_x, at_y, carve_dir, wall_bits, maze_done,
		output ready);
endinterface

interface gmdc_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [5:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/gmdc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gmdc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/gmdc_pick.sv */
// Neighbor choice: count open neighbors, reduce the random word, select one.
`default_nettype none

module gmdc_pick import gmdc_pkg::*; (
	input  logic [3:0] open_mask,
	input  logic [7:0] rand_value,
	output pick_t      pick
);

	logic [2:0] cnt;
	logic [3:0] dsum;
	logic [2:0] fold;
	logic [1:0] m3;
	logic [1:0] k;
	logic [1:0] seen;
	logic       found;
	logic [1:0] slot;

	always_comb begin
		cnt  = 3'(open_mask[0]) + 3'(open_mask[1]) + 3'(open_mask[2]) + 3'(open_mask[3]);
		// 4 = 1 mod 3: base-4 digit sum keeps the residue
		dsum = 4'(rand_value[1:0]) + 4'(rand_value[3:2]) + 4'(rand_value[5:4])
			+ 4'(rand_value[7:6]);
		fold = 3'(dsum[3:2]) + 3'(dsum[1:0]);
		priority if (fold >= 3'd6) begin
			m3 = 2'd0;
		end else if (fold >= 3'd3) begin
			m3 = 2'(fold - 3'd3);
		end else begin
			m3 = 2'(fold);
		end
		unique case (cnt)
			3'd2: k = {1'b0, rand_value[0]};
			3'd3: k = m3;
			3'd4: k = rand_value[1:0];
			default: k = 2'd0;
		endcase
	end

	always_comb begin
		seen  = 2'd0;
		found = 1'b0;
		slot  = 2'd0;
		for (int i = 0; i < 4; i++) begin
			if (open_mask[i] && !found) begin
				if (seen == k) begin
					found = 1'b1;
					slot  = 2'(i);
				end
				seen = seen + 2'd1;
			end
		end
		pick.any  = (cnt != 3'd0);
		pick.slot = slot;
		pick.dir  = SLOT_DIR[slot];
	end

endmodule

`default_nettype wire

/* rtl/grid_maze_dfs_carver_core.sv */
// Maze carver top: sequencer around the cell memory and the path stack memory.
//
//  channel | dir | beat contents
//  cmd     | in  | action, rand_value, cell_x, cell_y
//  evt     | out | event_kind, at_x, at_y, carve_dir, wall_bits, maze_done
//  cfg     | in  | index (0 grid_width, 1 grid_height), data
//
// One item at a time. The cell memory has a single read port: a carve or backtrack step
// reads the current cell plus four neighbors, one per cycle. Every 16th start adds a
// clearing pass.
// After reset a clearing pass writes all 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) cell
// entries with cmd.ready low; cfg is always ready.
// A result waits in the output register; a stalled evt holds the sequencer in its
// last state.
`default_nettype none
`include "grid_maze_dfs_carver_core_macros.svh"

module grid_maze_dfs_carver_core import gmdc_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = 32,
	parameter int unsigned MAX_HEIGHT = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	gmdc_cmd_if.sink cmd,
	gmdc_evt_if.source evt,
	gmdc_cfg_if.sink cfg
);

	localparam int unsigned XW    = $clog2(MAX_WIDTH);
	localparam int unsigned YW    = $clog2(MAX_HEIGHT);
	localparam int unsigned CAW   = XW + YW;
	localparam int unsigned CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned SAW   = $clog2(CELLS);
	localparam int unsigned DW    = $clog2(CELLS + 1);
	localparam int unsigned CW    = $bits(cell_t);

	typedef enum logic [9:0] {
		S_CLEAR = 10'b00_0000_0001,
		S_IDLE  = 10'b00_0000_0010,
		S_START = 10'b00_0000_0100,
		S_SEED  = 10'b00_0000_1000,
		S_RDC   = 10'b00_0001_0000,
		S_STK   = 10'b00_0010_0000,
		S_NB    = 10'b00_0100_0000,
		S_DEC   = 10'b00_1000_0000,
		S_WR2   = 10'b01_0000_0000,
		S_RESP  = 10'b10_0000_0000
	} state_t;

	function automatic logic [SZW-1:0] eff_size(logic [5:0] r, logic [SZW-1:0] maxv);
		logic [SZW-1:0] rv;
		rv = SZW'(r);
		if (r == 6'd0) return SZW'(1);
		if (rv > maxv) return maxv;
		return rv;
	endfunction

	// control
	state_t         state_q;
	logic [CAW-1:0] clr_addr_q;
	logic           start_pend_q;
	logic [EPW-1:0] epoch_q;
	logic [DW-1:0]  depth_q;
	logic [2:0]     nb_k_q;
	logic           out_valid_q;
	logic [5:0]     grid_w_q;
	logic [5:0]     grid_h_q;

	// payload
	logic [7:0]     rand_q;
	logic [4:0]     rx_q;
	logic [4:0]     ry_q;
	logic           rd_ok_q;
	logic [CAW-1:0] cur_q;
	cell_t          cur_cell_q;
	cell_t          nb_cell_q [4];
	logic [CAW-1:0] nxt_q;
	logic [3:0]     nxt_walls_q;
	result_t        res_q;
	result_t        out_q;
	logic           out_done_q;

	// memory ports
	logic           cm_we;
	logic [CAW-1:0] cm_waddr;
	cell_t          cm_wdata;
	logic           cm_re;
	logic [CAW-1:0] cm_raddr;
	logic [CW-1:0]  cm_rdata_raw;
	cell_t          cm_rdata;
	logic           sm_we;
	logic [SAW-1:0] sm_waddr;
	logic [CAW-1:0] sm_wdata;
	logic           sm_re;
	logic [SAW-1:0] sm_raddr;
	logic [CAW-1:0] sm_rdata;

	// decision
	logic           accept;
	logic           out_free;
	logic           step_empty;
	logic           rd_in;
	logic [CAW-1:0] rd_addr;
	cell_t          rd_v;
	logic [XW-1:0]  cx;
	logic [YW-1:0]  cy;
	logic [CAW-1:0] nb_addr [4];
	cell_t          cur_v;
	cell_t          nb_v [4];
	logic [SZW-1:0] eff_w;
	logic [SZW-1:0] eff_h;
	logic [3:0]     bnd;
	logic [3:0]     open_mask;
	pick_t          pick;
	logic           carve;
	logic [1:0]     odir;
	logic [3:0]     cur_new_walls;

	assign cmd.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign accept    = cmd.valid && (state_q == S_IDLE);
	assign out_free  = !out_valid_q || evt.ready;
	assign cm_rdata  = cell_t'(cm_rdata_raw);
	assign rd_v      = cell_view(cm_rdata, epoch_q);

	assign step_empty = (depth_q == '0) || (depth_q > DW'(CELLS));
	assign rd_in      = (32'(cmd.cell_x) < MAX_WIDTH) && (32'(cmd.cell_y) < MAX_HEIGHT);
	assign rd_addr    = {YW'(cmd.cell_y), XW'(cmd.cell_x)};

	assign cx = cur_q[XW-1:0];
	assign cy = cur_q[CAW-1:XW];

	always_comb begin
		nb_addr[0] = {cy, cx - XW'(1)};
		nb_addr[1] = {cy, cx + XW'(1)};
		nb_addr[2] = {cy - YW'(1), cx};
		nb_addr[3] = {cy + YW'(1), cx};
		cur_v = cell_view(cur_cell_q, epoch_q);
		for (int i = 0; i < 4; i++) begin
			nb_v[i] = cell_view(nb_cell_q[i], epoch_q);
		end
		eff_w  = eff_size(grid_w_q, SZW'(MAX_WIDTH));
		eff_h  = eff_size(grid_h_q, SZW'(MAX_HEIGHT));
		bnd[0] = (cx != '0);
		bnd[1] = (SZW'(cx) + SZW'(1)) < eff_w;
		bnd[2] = (cy != '0);
		bnd[3] = (SZW'(cy) + SZW'(1)) < eff_h;
		for (int i = 0; i < 4; i++) begin
			open_mask[i] = bnd[i] && !nb_v[i].visited;
		end
	end

	gmdc_pick u_pick (
		.open_mask  (open_mask),
		.rand_value (rand_q),
		.pick       (pick)
	);

	assign carve         = pick.any && (depth_q < DW'(CELLS));
	assign odir          = pick.dir ^ 2'b01;
	assign cur_new_walls = cur_v.walls & ~(4'b0001 << pick.dir);

	// memory access per state
	always_comb begin
		cm_we    = 1'b0;
		cm_waddr = clr_addr_q;
		cm_wdata = '{tag: '0, visited: 1'b0, walls: WALLS_ALL};
		cm_re    = 1'b0;
		cm_raddr = rd_addr;
		sm_we    = 1'b0;
		sm_waddr = depth_q[SAW-1:0];
		sm_wdata = nb_addr[pick.slot];
		sm_re    = 1'b0;
		sm_raddr = SAW'(depth_q - DW'(1));
		unique case (state_q)
			S_CLEAR: begin
				cm_we = 1'b1;
			end
			S_IDLE: begin
				cm_re = accept && (cmd.action == ACT_READ) && rd_in;
				sm_re = accept && (cmd.action == ACT_STEP) && !step_empty;
			end
			S_SEED: begin
				cm_we    = 1'b1;
				cm_waddr = '0;
				cm_wdata = '{tag: epoch_q, visited: 1'b1, walls: WALLS_ALL};
				sm_we    = 1'b1;
				sm_waddr = '0;
				sm_wdata = '0;
			end
			S_STK: begin
				cm_re    = 1'b1;
				cm_raddr = sm_rdata;
			end
			S_NB: begin
				cm_re    = !nb_k_q[2];
				cm_raddr = nb_addr[nb_k_q[1:0]];
			end
			S_DEC: begin
				cm_we    = carve;
				cm_waddr = cur_q;
				cm_wdata = '{tag: epoch_q, visited: cur_v.visited, walls: cur_new_walls};
				sm_we    = carve;
			end
			S_WR2: begin
				cm_we    = 1'b1;
				cm_waddr = nxt_q;
				cm_wdata = '{tag: epoch_q, visited: 1'b1, walls: nxt_walls_q};
			end
			default: begin
			end
		endcase
	end

	gmdc_ram #(.WIDTH(CW), .DEPTH(2 ** CAW)) u_cell_ram (
		.clk   (clk),
		.we    (cm_we),
		.waddr (cm_waddr),
		.wdata (cm_wdata),
		.re    (cm_re),
		.raddr (cm_raddr),
		.rdata (cm_rdata_raw)
	);

	gmdc_ram #(.WIDTH(CAW), .DEPTH(CELLS)) u_stack_ram (
		.clk   (clk),
		.we    (sm_we),
		.waddr (sm_waddr),
		.wdata (sm_wdata),
		.re    (sm_re),
		.raddr (sm_raddr),
		.rdata (sm_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_addr_q   <= '0;
			start_pend_q <= 1'b0;
			epoch_q      <= '0;
			depth_q      <= '0;
			nb_k_q       <= '0;
			out_valid_q  <= 1'b0;
			grid_w_q     <= GRID_RESET;
			grid_h_q     <= GRID_RESET;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_GRID_WIDTH:  grid_w_q <= cfg.data;
					REG_GRID_HEIGHT: grid_h_q <= cfg.data;
					default: begin
					end
				endcase
			end
			if ((state_q == S_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (evt.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + CAW'(1);
					if (clr_addr_q == '1) begin
						state_q      <= start_pend_q ? S_SEED : S_IDLE;
						start_pend_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (cmd.valid) begin
						unique case (cmd.action)
							ACT_START: state_q <= S_START;
							ACT_STEP: begin
								if (step_empty) begin
									depth_q <= '0;
									state_q <= S_RESP;
								end else begin
									state_q <= S_STK;
								end
							end
							ACT_READ: state_q <= S_RDC;
							default: begin
							end
						endcase
					end
				end
				S_START: begin
					epoch_q <= epoch_q + EPW'(1);
					if (epoch_q == '1) begin
						start_pend_q <= 1'b1;
						state_q      <= S_CLEAR;
					end else begin
						state_q <= S_SEED;
					end
				end
				S_SEED: begin
					depth_q <= DW'(1);
					state_q <= S_RESP;
				end
				S_RDC: state_q <= S_RESP;
				S_STK: begin
					nb_k_q  <= '0;
					state_q <= S_NB;
				end
				S_NB: begin
					nb_k_q <= nb_k_q + 3'd1;
					if (nb_k_q == 3'd4) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (carve) begin
						depth_q <= depth_q + DW'(1);
						state_q <= S_WR2;
					end else begin
						depth_q <= depth_q - DW'(1);
						state_q <= S_RESP;
					end
				end
				S_WR2: state_q <= S_RESP;
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					rand_q  <= cmd.rand_value;
					rx_q    <= cmd.cell_x;
					ry_q    <= cmd.cell_y;
					rd_ok_q <= rd_in;
					res_q   <= '{EV_FINISHED, 5'd0, 5'd0, DIR_XM, 4'd0};
				end
			end
			S_SEED: res_q <= '{EV_STARTED, 5'd0, 5'd0, DIR_XM, WALLS_ALL};
			S_RDC: begin
				res_q <= '{EV_WALLS, rx_q, ry_q, DIR_XM, rd_ok_q ? rd_v.walls : WALLS_ALL};
			end
			S_STK: cur_q <= sm_rdata;
			S_NB: begin
				if (nb_k_q == 3'd0) begin
					cur_cell_q <= cm_rdata;
				end else begin
					nb_cell_q[2'(nb_k_q - 3'd1)] <= cm_rdata;
				end
			end
			S_DEC: begin
				nxt_q       <= nb_addr[pick.slot];
				nxt_walls_q <= nb_v[pick.slot].walls & ~(4'b0001 << odir);
				if (carve) begin
					res_q <= '{EV_CARVED, 5'(cx), 5'(cy), pick.dir, cur_new_walls};
				end else begin
					res_q <= '{EV_BACKTRACKED, 5'(cx), 5'(cy), DIR_XM, cur_v.walls};
				end
			end
			S_RESP: begin
				if (out_free) begin
					out_q      <= res_q;
					out_done_q <= (depth_q == '0);
				end
			end
			default: begin
			end
		endcase
	end

	assign evt.valid      = out_valid_q;
	assign evt.event_kind = out_q.kind;
	assign evt.at_x       = out_q.x;
	assign evt.at_y       = out_q.y;
	assign evt.carve_dir  = out_q.dir;
	assign evt.wall_bits  = out_q.walls;
	assign evt.maze_done  = out_done_q;

	`GMDC_AST_IMP(a_cell_rw_apart, clk, arst_n, cm_we && cm_re, cm_waddr != cm_raddr, "cell memory read and write hit one entry")
	`GMDC_AST_IMP(a_depth_bound, clk, arst_n, 1'b1, depth_q <= DW'(CELLS), "stack depth above cell count")
	`GMDC_AST_NXT(a_push_grows, clk, arst_n, (state_q == S_DEC) && carve, depth_q == $past(depth_q) + DW'(1), "carve did not push")
	`GMDC_AST_IMP(a_out_from_resp, clk, arst_n, $rose(out_valid_q), $past(state_q == S_RESP), "result without response state")

endmodule

`default_nettype wire
